>>> hdl/asgd_pkg.sv
// Shared types and constants for the Adam/SGD parameter update block.
// Used by asgd_mem, asgd_div and adam_sgd_parameter_update.
package asgd_pkg;

  localparam int PARAM_COUNT = 65536;
  localparam int MEM_AW      = $clog2(PARAM_COUNT);
  localparam int ACC_W       = 84;
  localparam int DIV_NW      = 80;
  localparam int DIV_RW      = 34;
  localparam int ITER_W      = 7;

  localparam logic [32:0] ONE32 = 33'h1_0000_0000;
  localparam logic [47:0] V_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [31:0] LR_RESET  = 32'd42949673;
  localparam logic [31:0] B1_RESET  = 32'd3865470566;
  localparam logic [31:0] B2_RESET  = 32'd4290672329;
  localparam logic [30:0] EPS_RESET = 31'd1;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_LR    = 3'd1;
  localparam logic [2:0] REG_B1    = 3'd2;
  localparam logic [2:0] REG_B2    = 3'd3;
  localparam logic [2:0] REG_EPS   = 3'd4;
  localparam logic [2:0] REG_STEPS = 3'd5;

  localparam logic [ITER_W-1:0] IT_GRAD = 7'd40;
  localparam logic [ITER_W-1:0] IT_MH   = 7'd64;
  localparam logic [ITER_W-1:0] IT_VH   = 7'd80;
  localparam logic [ITER_W-1:0] IT_ROOT = 7'd28;
  localparam logic [ITER_W-1:0] IT_STEP = 7'd64;

  typedef enum logic [26:0] {
    ST_IDLE      = 27'h0000001,
    ST_G_LAUNCH  = 27'h0000002,
    ST_G_WAIT    = 27'h0000004,
    ST_SGD_MUL   = 27'h0000008,
    ST_SGD_TAKE  = 27'h0000010,
    ST_BP1       = 27'h0000020,
    ST_BP2       = 27'h0000040,
    ST_MA        = 27'h0000080,
    ST_MB        = 27'h0000100,
    ST_SQ        = 27'h0000200,
    ST_VA        = 27'h0000400,
    ST_VB        = 27'h0000800,
    ST_VC        = 27'h0001000,
    ST_VD        = 27'h0002000,
    ST_VE        = 27'h0004000,
    ST_WB        = 27'h0008000,
    ST_MH_LAUNCH = 27'h0010000,
    ST_MH_WAIT   = 27'h0020000,
    ST_VH_LAUNCH = 27'h0040000,
    ST_VH_WAIT   = 27'h0080000,
    ST_RT_LAUNCH = 27'h0100000,
    ST_RT_WAIT   = 27'h0200000,
    ST_LR_MUL    = 27'h0400000,
    ST_LR_TAKE   = 27'h0800000,
    ST_SD_LAUNCH = 27'h1000000,
    ST_SD_WAIT   = 27'h2000000,
    ST_FINISH    = 27'h4000000
  } state_t;

  typedef enum logic [3:0] {
    TG_NONE, TG_BP1, TG_BP2, TG_MA, TG_MB, TG_SQ,
    TG_VA, TG_VB, TG_VC, TG_VD, TG_SGD, TG_LRM
  } tag_t;

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [ITER_W-1:0] iters;
    logic [DIV_NW-1:0] num;
    logic [32:0]       den;
  } div_req_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [31:0]       m;
    logic [47:0]       v;
  } mem_wr_t;

endpackage

>>> hdl/adam_sgd_parameter_update.sv
// Adam / SGD per-element parameter update; top level with sequencer and config port.
// Adam mode runs the serial divider and root unit for the gradient, m-hat, v-hat, root and step;
// SGD mode for the gradient only, and new_step also advances the beta powers. One item at a
// time: the next input is taken in the cycle after the result loads; a held result stalls
// the input. Reset: synchronous active-low; the moment store is then zeroed while in_tready
// stays low. Depends on asgd_pkg, asgd_mem, asgd_mul, asgd_div.
module adam_sgd_parameter_update (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // element_index, param_value, grad_sum, sample_count
  input  logic         in_tuser,   // new_step
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // out_index, new_param
  output logic         out_tuser,  // clipped
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import asgd_pkg::*;

  state_t state_r, state_nxt;
  tag_t   tag_r, tag_nxt;

  logic        optimizer_mode_r;
  logic [31:0] learning_rate_r, beta_one_r, beta_two_r;
  logic [30:0] epsilon_term_r;
  logic [31:0] step_cnt_r;
  logic [32:0] bp1_r, bp2_r;

  logic [15:0]       idx_r;
  logic [31:0]       param_r;
  logic              gsum_neg_r;
  logic [39:0]       gsum_mag_r;
  logic [15:0]       count_r;
  logic              nstep_r;
  logic              clip_r;
  logic [31:0]       g_mag_r;
  logic              g_neg_r;
  logic [ACC_W-1:0]  acc_r;
  logic [47:0]       sq_r;
  logic [31:0]       m_new_r;
  logic [47:0]       v_new_r;
  logic [31:0]       mh_r;
  logic [47:0]       vh_r;
  logic [31:0]       den_r;
  logic [63:0]       lrm_r;
  logic [33:0]       stepmag_r;
  logic              sign_r;
  logic              out_valid_r;
  logic [47:0]       out_data_r;
  logic              out_user_r;

  logic              in_fire;
  logic              out_load;
  logic              cfg_wr;
  logic              mem_ready;
  logic [31:0]       mem_rd_m;
  logic [47:0]       mem_rd_v;
  mem_wr_t           mem_wr;
  div_req_t          div_req;
  logic              div_busy, div_done;
  logic [DIV_NW-1:0] div_quo;
  logic [32:0]       mul_a, mul_b;
  logic [65:0]       mul_p;
  logic [ACC_W-1:0]  p_ext, p_sh;
  logic [32:0]       m_old_mag;
  logic [31:0]       m_new_mag;
  logic [32:0]       bc1, bc2;
  logic [39:0]       g_q;
  logic [31:0]       den_sum;
  logic [34:0]       res;
  logic [31:0]       res_sat;
  logic              res_clip;
  logic              clip_set;
  logic [15:0]       in_cnt;

  assign in_tready  = (state_r == ST_IDLE) && mem_ready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  asgd_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_tdata[MEM_AW-1:0]),
    .wr      (mem_wr),
    .rd_m    (mem_rd_m),
    .rd_v    (mem_rd_v),
    .ready   (mem_ready)
  );

  asgd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  asgd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign p_ext     = {{(ACC_W-66){1'b0}}, mul_p};
  assign p_sh      = p_ext << 32;
  assign m_old_mag = mem_rd_m[31] ? 33'(~{1'b1, mem_rd_m} + 1'b1) : {1'b0, mem_rd_m};
  assign m_new_mag = m_new_r[31] ? 32'(~m_new_r + 1'b1) : m_new_r;
  assign bc1       = (bp1_r == ONE32) ? ONE32 : 33'(ONE32 - bp1_r);
  assign bc2       = (bp2_r == ONE32) ? ONE32 : 33'(ONE32 - bp2_r);
  assign g_q       = div_quo[39:0];
  assign den_sum   = 32'({4'b0, div_quo[27:0]}) + {1'b0, epsilon_term_r};
  assign in_cnt    = in_tdata[103:88];

  always_comb begin
    res = {{3{param_r[31]}}, param_r} +
          (sign_r ? {1'b0, stepmag_r} : 35'(~{1'b0, stepmag_r} + 1'b1));
    res_clip = !((res[34:31] == 4'b0000) || (res[34:31] == 4'b1111));
    if (!res_clip) begin
      res_sat = res[31:0];
    end else if (res[34]) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    tag_nxt = TG_NONE;
    case (state_r)
      ST_SGD_MUL: begin
        mul_a = {1'b0, learning_rate_r}; mul_b = {1'b0, g_mag_r}; tag_nxt = TG_SGD;
      end
      ST_BP1: begin
        mul_a = bp1_r; mul_b = {1'b0, beta_one_r}; tag_nxt = TG_BP1;
      end
      ST_BP2: begin
        mul_a = bp2_r; mul_b = {1'b0, beta_two_r}; tag_nxt = TG_BP2;
      end
      ST_MA: begin
        mul_a = {1'b0, beta_one_r}; mul_b = m_old_mag; tag_nxt = TG_MA;
      end
      ST_MB: begin
        mul_a = 33'(ONE32 - {1'b0, beta_one_r}); mul_b = {1'b0, g_mag_r}; tag_nxt = TG_MB;
      end
      ST_SQ: begin
        mul_a = {1'b0, g_mag_r}; mul_b = {1'b0, g_mag_r}; tag_nxt = TG_SQ;
      end
      ST_VA: begin
        mul_a = {1'b0, mem_rd_v[31:0]}; mul_b = {1'b0, beta_two_r}; tag_nxt = TG_VA;
      end
      ST_VB: begin
        mul_a = {17'b0, mem_rd_v[47:32]}; mul_b = {1'b0, beta_two_r}; tag_nxt = TG_VB;
      end
      ST_VC: begin
        mul_a = {1'b0, sq_r[31:0]}; mul_b = 33'(ONE32 - {1'b0, beta_two_r}); tag_nxt = TG_VC;
      end
      ST_VD: begin
        mul_a = {17'b0, sq_r[47:32]}; mul_b = 33'(ONE32 - {1'b0, beta_two_r});
        tag_nxt = TG_VD;
      end
      ST_LR_MUL: begin
        mul_a = {1'b0, learning_rate_r}; mul_b = {1'b0, mh_r}; tag_nxt = TG_LRM;
      end
      default: begin
        tag_nxt = TG_NONE;
      end
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state_r)
      ST_G_LAUNCH: begin
        div_req.start = 1'b1;
        div_req.iters = IT_GRAD;
        div_req.num   = {gsum_mag_r, 40'b0};
        div_req.den   = {17'b0, count_r};
      end
      ST_MH_LAUNCH: begin
        div_req.start = 1'b1;
        div_req.iters = IT_MH;
        div_req.num   = {m_new_mag, 48'b0};
        div_req.den   = bc1;
      end
      ST_VH_LAUNCH: begin
        div_req.start = 1'b1;
        div_req.iters = IT_VH;
        div_req.num   = {v_new_r, 32'b0};
        div_req.den   = bc2;
      end
      ST_RT_LAUNCH: begin
        div_req.start     = 1'b1;
        div_req.sqrt_mode = 1'b1;
        div_req.iters     = IT_ROOT;
        div_req.num       = {vh_r, 32'b0};
      end
      ST_SD_LAUNCH: begin
        div_req.start = 1'b1;
        div_req.iters = IT_STEP;
        div_req.num   = {lrm_r, 16'b0};
        div_req.den   = {1'b0, den_r};
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    mem_wr      = '0;
    mem_wr.en   = (state_r == ST_WB);
    mem_wr.addr = idx_r[MEM_AW-1:0];
    mem_wr.m    = m_new_r;
    mem_wr.v    = acc_r[79:32];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_fire) state_nxt = ST_G_LAUNCH;
      ST_G_LAUNCH:  state_nxt = ST_G_WAIT;
      ST_G_WAIT: begin
        if (div_done) begin
          if (!optimizer_mode_r) begin
            state_nxt = ST_SGD_MUL;
          end else if (nstep_r) begin
            state_nxt = ST_BP1;
          end else begin
            state_nxt = ST_MA;
          end
        end
      end
      ST_SGD_MUL:   state_nxt = ST_SGD_TAKE;
      ST_SGD_TAKE:  state_nxt = ST_FINISH;
      ST_BP1:       state_nxt = ST_BP2;
      ST_BP2:       state_nxt = ST_MA;
      ST_MA:        state_nxt = ST_MB;
      ST_MB:        state_nxt = ST_SQ;
      ST_SQ:        state_nxt = ST_VA;
      ST_VA:        state_nxt = ST_VB;
      ST_VB:        state_nxt = ST_VC;
      ST_VC:        state_nxt = ST_VD;
      ST_VD:        state_nxt = ST_VE;
      ST_VE:        state_nxt = ST_WB;
      ST_WB:        state_nxt = ST_MH_LAUNCH;
      ST_MH_LAUNCH: state_nxt = ST_MH_WAIT;
      ST_MH_WAIT:   if (div_done) state_nxt = ST_VH_LAUNCH;
      ST_VH_LAUNCH: state_nxt = ST_VH_WAIT;
      ST_VH_WAIT:   if (div_done) state_nxt = ST_RT_LAUNCH;
      ST_RT_LAUNCH: state_nxt = ST_RT_WAIT;
      ST_RT_WAIT:   if (div_done) state_nxt = ST_LR_MUL;
      ST_LR_MUL:    state_nxt = ST_LR_TAKE;
      ST_LR_TAKE:   state_nxt = ST_SD_LAUNCH;
      ST_SD_LAUNCH: state_nxt = ST_SD_WAIT;
      ST_SD_WAIT:   if (div_done) state_nxt = ST_FINISH;
      ST_FINISH:    if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clip_set = 1'b0;
    if (state_r == ST_G_WAIT && div_done) begin
      clip_set = (g_q > (gsum_neg_r ? 40'h80000000 : 40'h7FFFFFFF));
    end
    if (tag_r == TG_SQ && mul_p[65:56] != '0) clip_set = 1'b1;
    if (state_r == ST_MH_WAIT && div_done) begin
      if (div_quo[63:0] > (m_new_r[31] ? 64'h80000000 : 64'h7FFFFFFF)) clip_set = 1'b1;
    end
    if (state_r == ST_VH_WAIT && div_done && div_quo[79:48] != '0) clip_set = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      tag_r            <= TG_NONE;
      out_valid_r      <= 1'b0;
      optimizer_mode_r <= 1'b0;
      learning_rate_r  <= LR_RESET;
      beta_one_r       <= B1_RESET;
      beta_two_r       <= B2_RESET;
      epsilon_term_r   <= EPS_RESET;
      step_cnt_r       <= '0;
      bp1_r            <= ONE32;
      bp2_r            <= ONE32;
    end else begin
      state_r <= state_nxt;
      tag_r   <= tag_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_MODE: optimizer_mode_r <= cfg_pwdata[0];
          REG_LR:   learning_rate_r  <= cfg_pwdata;
          REG_B1:   beta_one_r       <= cfg_pwdata;
          REG_B2:   beta_two_r       <= cfg_pwdata;
          REG_EPS:  epsilon_term_r   <= cfg_pwdata[30:0];
          default:  ;
        endcase
      end
      if (state_r == ST_BP1) step_cnt_r <= step_cnt_r + 1'b1;
      if (tag_r == TG_BP1) bp1_r <= mul_p[64:32];
      if (tag_r == TG_BP2) bp2_r <= mul_p[64:32];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r      <= in_tdata[15:0];
      param_r    <= in_tdata[47:16];
      gsum_neg_r <= in_tdata[87];
      gsum_mag_r <= in_tdata[87] ? 40'(~in_tdata[87:48] + 1'b1) : in_tdata[87:48];
      count_r    <= (in_cnt == '0) ? 16'd1 : in_cnt;
      nstep_r    <= in_tuser;
      clip_r     <= 1'b0;
    end else begin
      clip_r <= clip_r | clip_set;
    end

    case (tag_r)
      TG_MA:   acc_r <= mem_rd_m[31] ? ACC_W'(~p_ext + 1'b1) : p_ext;
      TG_MB:   acc_r <= acc_r + (g_neg_r ? ACC_W'(~p_ext + 1'b1) : p_ext);
      TG_SQ:   sq_r  <= (mul_p[65:56] != '0) ? V_MAX : mul_p[55:8];
      TG_VA:   acc_r <= p_ext;
      TG_VB:   acc_r <= acc_r + p_sh;
      TG_VC:   acc_r <= acc_r + p_ext;
      TG_VD:   acc_r <= acc_r + p_sh;
      TG_SGD:  stepmag_r <= (mul_p[65:32] > 34'h2_0000_0000) ? 34'h2_0000_0000
                                                              : mul_p[65:32];
      TG_LRM:  lrm_r <= mul_p[63:0];
      default: ;
    endcase

    case (state_r)
      ST_G_WAIT: begin
        if (div_done) begin
          g_neg_r <= gsum_neg_r;
          if (gsum_neg_r && g_q > 40'h80000000) begin
            g_mag_r <= 32'h8000_0000;
          end else if (!gsum_neg_r && g_q > 40'h7FFFFFFF) begin
            g_mag_r <= 32'h7FFF_FFFF;
          end else begin
            g_mag_r <= g_q[31:0];
          end
        end
      end
      ST_SGD_MUL: sign_r  <= g_neg_r;
      ST_VA:      m_new_r <= acc_r[63:32];
      ST_WB:      v_new_r <= acc_r[79:32];
      ST_MH_WAIT: begin
        if (div_done) begin
          sign_r <= m_new_r[31];
          if (m_new_r[31] && div_quo[63:0] > 64'h80000000) begin
            mh_r <= 32'h8000_0000;
          end else if (!m_new_r[31] && div_quo[63:0] > 64'h7FFFFFFF) begin
            mh_r <= 32'h7FFF_FFFF;
          end else begin
            mh_r <= div_quo[31:0];
          end
        end
      end
      ST_VH_WAIT: begin
        if (div_done) vh_r <= (div_quo[79:48] != '0) ? V_MAX : div_quo[47:0];
      end
      ST_RT_WAIT: begin
        if (div_done) den_r <= (den_sum == '0) ? 32'd1 : den_sum;
      end
      ST_SD_WAIT: begin
        if (div_done) begin
          stepmag_r <= (div_quo[63:8] > 56'h2_0000_0000) ? 34'h2_0000_0000
                                                          : div_quo[41:8];
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_data_r <= {res_sat, idx_r};
      out_user_r <= clip_r | res_clip;
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_MODE:  cfg_prdata = {31'b0, optimizer_mode_r};
      REG_LR:    cfg_prdata = learning_rate_r;
      REG_B1:    cfg_prdata = beta_one_r;
      REG_B2:    cfg_prdata = beta_two_r;
      REG_EPS:   cfg_prdata = {1'b0, epsilon_term_r};
      REG_STEPS: cfg_prdata = step_cnt_r;
      default:   cfg_prdata = '0;
    endcase
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy) else $error("divider started while busy");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    !mem_ready |-> !in_tready) else $error("input taken during moment clear");

  a_g_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MA |-> g_mag_r <= 32'h8000_0000) else $error("gradient not saturated");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> stepmag_r <= 34'h2_0000_0000) else $error("step not clamped");

  a_wr_adam: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> optimizer_mode_r) else $error("moment write in SGD mode");

endmodule

>>> hdl/asgd_mem.sv
// Moment store: first and second moment per element, registered read.
// Sweeps zeros through every entry after reset. Depends on asgd_pkg.
module asgd_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [asgd_pkg::MEM_AW-1:0] rd_addr,
  input  asgd_pkg::mem_wr_t         wr,
  output logic [31:0]               rd_m,
  output logic [47:0]               rd_v,
  output logic                      ready
);
  import asgd_pkg::*;

  logic [31:0]     m_mem [PARAM_COUNT];
  logic [47:0]     v_mem [PARAM_COUNT];
  logic [MEM_AW:0] clr_cnt_r;
  logic [MEM_AW:0] clr_cnt_nxt;

  assign ready       = clr_cnt_r[MEM_AW];
  assign clr_cnt_nxt = ready ? clr_cnt_r : clr_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      m_mem[clr_cnt_r[MEM_AW-1:0]] <= '0;
      v_mem[clr_cnt_r[MEM_AW-1:0]] <= '0;
    end else if (wr.en) begin
      m_mem[wr.addr] <= wr.m;
      v_mem[wr.addr] <= wr.v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_m <= m_mem[rd_addr];
      rd_v <= v_mem[rd_addr];
    end
  end

endmodule

>>> hdl/asgd_mul.sv
// Shared 33x33 unsigned multiplier with registered product.
// Depends on nothing beyond its ports.
module asgd_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] p_r
);

  logic [65:0] p_nxt;

  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

>>> hdl/asgd_div.sv
// Shared restoring divider and square root unit, one quotient or root bit per cycle.
// Depends on asgd_pkg.
module asgd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  asgd_pkg::div_req_t          req,
  output logic                        busy,
  output logic                        done,
  output logic [asgd_pkg::DIV_NW-1:0] quo
);
  import asgd_pkg::*;

  logic [DIV_NW-1:0] num_r, num_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_RW-1:0] rem_r, rem_nxt;
  logic [32:0]       den_r;
  logic              sqrt_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_RW:0]   cand;
  logic [DIV_RW:0]   sub;
  logic              ge;

  always_comb begin
    if (sqrt_r) begin
      cand    = {rem_r[DIV_RW-2:0], num_r[DIV_NW-1 -: 2]};
      sub     = {1'b0, quo_r[31:0], 2'b01};
      num_nxt = {num_r[DIV_NW-3:0], 2'b00};
    end else begin
      cand    = {rem_r, num_r[DIV_NW-1]};
      sub     = {2'b00, den_r};
      num_nxt = {num_r[DIV_NW-2:0], 1'b0};
    end
    ge      = cand >= sub;
    rem_nxt = ge ? DIV_RW'(cand - sub) : DIV_RW'(cand);
    quo_nxt = {quo_r[DIV_NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r  <= req.num;
      den_r  <= req.den;
      sqrt_r <= req.sqrt_mode;
      quo_r  <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule
